// File: sv/gals_pkg.sv
// ----------------------------------------------------------------------------
// gals_pkg
// Shared types and constants of the graph adjacency list store.
// ----------------------------------------------------------------------------
package gals_pkg;

   localparam int POOL_SLOTS = 1024;
   localparam int VERTEX_MAX = 128;

   localparam int PTR_W    = $clog2(POOL_SLOTS);
   localparam int FREE_W   = PTR_W + 1;
   localparam int VERTEX_W = $clog2(VERTEX_MAX);
   localparam int WEIGHT_W = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [PTR_W-1:0] REMOVED_CODE = {PTR_W{1'b1}};
   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = VERTEX_W'(100);

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EXISTS = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic [VERTEX_W-1:0]        src_vertex;
      logic [VERTEX_W-1:0]        dst_vertex;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic [PTR_W-1:0]           slot_pointer;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic                       found;
      logic [PTR_W-1:0]           adj_vertex;
      logic signed [WEIGHT_W-1:0] weight_out;
      logic [PTR_W-1:0]           next_pointer;
      logic                       list_end;
   } rsp_type;

   // One slot of the node memory: vertex word and link word side by side.
   typedef struct packed {
      logic [PTR_W-1:0] vertex;
      logic [PTR_W-1:0] link;
   } node_word_type;

   localparam int NODE_W = $bits(node_word_type);

   typedef struct packed {
      logic          we;
      logic [PTR_W-1:0] addr;
      node_word_type wdata;
   } node_req_type;

   typedef struct packed {
      logic                we;
      logic [PTR_W-1:0]    addr;
      logic [WEIGHT_W-1:0] wdata;
   } wgt_req_type;

endpackage

// File: sv/gals_ram.sv
// ----------------------------------------------------------------------------
// gals_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gals_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/gals_ctrl.sv
// ----------------------------------------------------------------------------
// gals_ctrl
// Command sequencer: walks lists, appends edges and clears heads through the
// node and weight memories, and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module gals_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gals_pkg::req_type               req_data,
   input  logic [gals_pkg::VERTEX_W-1:0]   vertex_count,
   output gals_pkg::node_req_type          node_req,
   input  gals_pkg::node_word_type         node_rdata,
   output gals_pkg::wgt_req_type           wgt_req,
   input  logic [gals_pkg::WEIGHT_W-1:0]   wgt_rdata,
   output logic                            rsp_valid,
   output gals_pkg::rsp_type               rsp_data
);

   typedef enum logic [3:0] {
      IDLE,
      CLEAR,
      INS_HEAD,
      INS_TAIL,
      INS_WR_SRC,
      INS_WR_POS,
      WALK_HEAD,
      WALK_STEP,
      RD_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic                             busy_ff;
   logic [gals_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [gals_pkg::VERTEX_W-1:0]    src_ff, src_in;
   logic [gals_pkg::VERTEX_W-1:0]    dst_ff, dst_in;
   logic [gals_pkg::WEIGHT_W-1:0]    wgt_ff, wgt_in;
   logic [gals_pkg::VERTEX_W-1:0]    cnt_ff, cnt_in;
   logic [gals_pkg::FREE_W-1:0]      free_ff, free_in;
   gals_pkg::node_word_type          hold_ff, hold_in;
   logic [gals_pkg::PTR_W-1:0]       cur_ff, cur_in;
   logic [gals_pkg::FREE_W-1:0]      steps_ff, steps_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   gals_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             accept;
   logic                             src_ok;
   logic                             dst_ok;
   logic [gals_pkg::PTR_W-1:0]       src_addr;
   logic [gals_pkg::PTR_W-1:0]       pos;
   logic                             hit;
   logic [gals_pkg::FREE_W-1:0]      steps_next;

   assign accept     = start && !busy_ff;
   assign src_ok     = req_data.src_vertex < vertex_count;
   assign dst_ok     = req_data.dst_vertex < vertex_count;
   assign src_addr   = gals_pkg::PTR_W'(src_ff);
   assign pos        = free_ff[gals_pkg::PTR_W-1:0];
   assign hit        = node_rdata.vertex == gals_pkg::PTR_W'(dst_ff);
   assign steps_next = steps_ff + gals_pkg::FREE_W'(1);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      wgt_in       = wgt_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      hold_in      = hold_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      node_req       = '0;
      node_req.addr  = src_addr;
      wgt_req        = '0;
      wgt_req.addr   = req_data.slot_pointer;
      wgt_req.wdata  = wgt_ff;

      case (state_ff)
         IDLE: begin
            // The first read goes out in the accept cycle.
            if (req_data.cmd == gals_pkg::CMD_NEXT) begin
               node_req.addr = req_data.slot_pointer;
            end else begin
               node_req.addr = gals_pkg::PTR_W'(req_data.src_vertex);
            end
            if (accept) begin
               cmd_in = req_data.cmd;
               src_in = req_data.src_vertex;
               dst_in = req_data.dst_vertex;
               wgt_in = req_data.edge_weight;
               case (req_data.cmd)
                  gals_pkg::CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = CLEAR;
                  end
                  gals_pkg::CMD_INSERT: begin
                     if (!src_ok || !dst_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = gals_pkg::ST_BAD_VERTEX;
                     end else if (free_ff >= gals_pkg::FREE_W'(gals_pkg::POOL_SLOTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = gals_pkg::ST_FULL;
                     end else begin
                        state_in = INS_HEAD;
                     end
                  end
                  gals_pkg::CMD_EXISTS, gals_pkg::CMD_REMOVE: begin
                     if (!src_ok || !dst_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = gals_pkg::ST_BAD_VERTEX;
                     end else begin
                        state_in = WALK_HEAD;
                     end
                  end
                  gals_pkg::CMD_FIRST: begin
                     if (!src_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = gals_pkg::ST_BAD_VERTEX;
                     end else begin
                        state_in = RD_DONE;
                     end
                  end
                  gals_pkg::CMD_NEXT: begin
                     state_in = RD_DONE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         CLEAR: begin
            node_req.we           = 1'b1;
            node_req.addr         = gals_pkg::PTR_W'(cnt_ff);
            node_req.wdata.vertex = gals_pkg::PTR_W'(cnt_ff);
            node_req.wdata.link   = '0;
            if (cnt_ff == vertex_count) begin
               free_in      = gals_pkg::FREE_W'(vertex_count);
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               cnt_in = cnt_ff + gals_pkg::VERTEX_W'(1);
            end
         end

         INS_HEAD: begin
            // Head word is here; its vertex word is the tail slot.
            hold_in       = node_rdata;
            node_req.addr = node_rdata.vertex;
            state_in      = INS_TAIL;
         end

         INS_TAIL: begin
            node_req.we           = 1'b1;
            node_req.addr         = hold_ff.vertex;
            node_req.wdata.vertex = node_rdata.vertex;
            node_req.wdata.link   = pos;
            state_in              = INS_WR_SRC;
         end

         INS_WR_SRC: begin
            // The head link follows the earlier writes when the head itself
            // was the tail or is the new slot.
            node_req.we           = 1'b1;
            node_req.addr         = src_addr;
            node_req.wdata.vertex = pos;
            if (src_addr == pos) begin
               node_req.wdata.link = '0;
            end else if (hold_ff.vertex == src_addr) begin
               node_req.wdata.link = pos;
            end else begin
               node_req.wdata.link = hold_ff.link;
            end
            state_in = INS_WR_POS;
         end

         INS_WR_POS: begin
            node_req.we   = 1'b1;
            node_req.addr = pos;
            if (src_addr == pos) begin
               node_req.wdata.vertex = pos;
            end else begin
               node_req.wdata.vertex = gals_pkg::PTR_W'(dst_ff);
            end
            node_req.wdata.link = '0;
            wgt_req.we          = 1'b1;
            wgt_req.addr        = pos;
            free_in             = free_ff + gals_pkg::FREE_W'(1);
            rsp_valid_in        = 1'b1;
            state_in            = IDLE;
         end

         WALK_HEAD: begin
            node_req.addr = node_rdata.link;
            cur_in        = node_rdata.link;
            steps_in      = '0;
            if (node_rdata.link == '0) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == gals_pkg::CMD_REMOVE) begin
                  rsp_in.status = gals_pkg::ST_NOT_FOUND;
               end
               state_in = IDLE;
            end else begin
               state_in = WALK_STEP;
            end
         end

         WALK_STEP: begin
            node_req.addr = node_rdata.link;
            cur_in        = node_rdata.link;
            steps_in      = steps_next;
            if (hit) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == gals_pkg::CMD_REMOVE) begin
                  node_req.we           = 1'b1;
                  node_req.addr         = cur_ff;
                  node_req.wdata.vertex = gals_pkg::REMOVED_CODE;
                  node_req.wdata.link   = node_rdata.link;
               end else begin
                  rsp_in.found = 1'b1;
               end
               state_in = IDLE;
            end else if (node_rdata.link == '0 ||
                         steps_next == gals_pkg::FREE_W'(gals_pkg::POOL_SLOTS)) begin
               // End of the list, or a walk that runs in a cycle.
               rsp_valid_in = 1'b1;
               if (cmd_ff == gals_pkg::CMD_REMOVE) begin
                  rsp_in.status = gals_pkg::ST_NOT_FOUND;
               end
               state_in = IDLE;
            end
         end

         RD_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.next_pointer = node_rdata.link;
            rsp_in.list_end     = node_rdata.link == '0;
            if (cmd_ff == gals_pkg::CMD_NEXT) begin
               rsp_in.adj_vertex = node_rdata.vertex;
               rsp_in.weight_out = wgt_rdata;
            end
            state_in = IDLE;
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         busy_ff      <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= state_in != IDLE;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      wgt_ff   <= wgt_in;
      cnt_ff   <= cnt_in;
      hold_ff  <= hold_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/graph_adjacency_list_store_top.sv
// ----------------------------------------------------------------------------
// graph_adjacency_list_store_top
// Weighted directed graph kept as linked adjacency lists in slot memories.
// ----------------------------------------------------------------------------
// A command word is taken on req_data at a clock edge with start high and
// busy low. Each command returns one result word on rsp_data, marked by
// rsp_valid for exactly one cycle; the receiver takes it unconditionally.
// A bad vertex, a full pool or an unknown code is answered in the cycle
// after the accept. First and next read the node word, next also the
// weight, and answer from RD_DONE. Insert passes INS_HEAD, INS_TAIL,
// INS_WR_SRC and INS_WR_POS. Exists and remove walk the list, one node
// memory read per list slot visited. Clear writes one head per cycle.
// The single-port node memory serializes every access, so one command is in
// progress at a time; a new one may start in the cycle its result shows.
// vertex_count is written through csr_valid/csr_data, always ready; the
// user must write it only while no command is in progress, which the block
// itself does not enforce. Reset sets vertex_count to 100 and the free
// pointer to zero; memory contents are undefined until a clear.
// ----------------------------------------------------------------------------
module graph_adjacency_list_store_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gals_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output gals_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gals_pkg::VERTEX_W-1:0]   csr_data
);

   logic [gals_pkg::VERTEX_W-1:0]  vertex_count_ff;
   gals_pkg::node_req_type         node_req;
   gals_pkg::wgt_req_type          wgt_req;
   logic [gals_pkg::NODE_W-1:0]    node_rdata_raw;
   gals_pkg::node_word_type        node_rdata;
   logic [gals_pkg::WEIGHT_W-1:0]  wgt_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= gals_pkg::VERTEX_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         vertex_count_ff <= csr_data;
      end
   end

   gals_ram #(
      .WIDTH (gals_pkg::NODE_W),
      .DEPTH (gals_pkg::POOL_SLOTS)
   ) u_node_ram (
      .clock (clock),
      .we    (node_req.we),
      .addr  (node_req.addr),
      .wdata (node_req.wdata),
      .rdata (node_rdata_raw)
   );

   assign node_rdata = gals_pkg::node_word_type'(node_rdata_raw);

   gals_ram #(
      .WIDTH (gals_pkg::WEIGHT_W),
      .DEPTH (gals_pkg::POOL_SLOTS)
   ) u_wgt_ram (
      .clock (clock),
      .we    (wgt_req.we),
      .addr  (wgt_req.addr),
      .wdata (wgt_req.wdata),
      .rdata (wgt_rdata)
   );

   gals_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .vertex_count (vertex_count_ff),
      .node_req     (node_req),
      .node_rdata   (node_rdata),
      .wgt_req      (wgt_req),
      .wgt_rdata    (wgt_rdata),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule
